// File: design/lmsd_pkg.sv
package lmsd_pkg;

   typedef logic [2:0] kind_type;

   localparam kind_type KIND_TICK      = 3'd0;
   localparam kind_type KIND_SET       = 3'd1;
   localparam kind_type KIND_CLEAR     = 3'd2;
   localparam kind_type KIND_CLEAR_ALL = 3'd3;
   localparam kind_type KIND_FILL_ALL  = 3'd4;

   localparam logic [7:0] ROW_PERIOD_RESET = 8'd128;
   localparam logic [7:0] BYTES_PER_PANEL  = 8'd12;
   localparam logic [3:0] PIXEL_COLS       = 4'd12;
   localparam logic [7:0] BYTE_CLEAR       = 8'h00;
   localparam logic [7:0] BYTE_FILL        = 8'hff;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_EXEC
   } lmsd_state_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } lmsd_cmd_type;

   typedef struct packed {
      logic out_free;
   } lmsd_status_type;

endpackage

// File: design/lmsd_ctrl.sv
module lmsd_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  lmsd_pkg::lmsd_status_type status,
   output lmsd_pkg::lmsd_cmd_type    cmd
);

   lmsd_pkg::lmsd_state_type state_ff;
   lmsd_pkg::lmsd_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lmsd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lmsd_pkg::ST_IDLE: begin
            if (req_valid) state_in = lmsd_pkg::ST_EXEC;
         end
         lmsd_pkg::ST_EXEC: begin
            if (status.out_free) state_in = lmsd_pkg::ST_IDLE;
         end
         default: state_in = lmsd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      case (state_ff)
         lmsd_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         lmsd_pkg::ST_EXEC: begin
            // hold until the result register can take the new result
            cmd.commit = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// File: design/lmsd_datapath.sv
module lmsd_datapath #(
   parameter int PANEL_COUNT  = 2,
   parameter int COLUMN_COUNT = 6
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lmsd_pkg::lmsd_cmd_type    cmd,
   output lmsd_pkg::lmsd_status_type status,
   input  logic [7:0]                row_period,
   input  logic [2:0]                req_kind,
   input  logic [7:0]                req_brightness,
   input  logic                      req_shift_done,
   input  logic [3:0]                req_pixel_x,
   input  logic [3:0]                req_pixel_y,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_shift_byte,
   output logic                      rsp_shift_start,
   output logic                      rsp_latch_pulse,
   output logic [2:0]                rsp_column_select,
   output logic                      rsp_blank
);

   localparam int DEPTH     = 12 * PANEL_COUNT;
   localparam int AW        = $clog2(DEPTH);
   localparam int BCW       = $clog2(2 * PANEL_COUNT);
   localparam int LAST_BYTE = 2 * PANEL_COUNT - 1;
   localparam int ROWS      = 8 * PANEL_COUNT;
   localparam int LAST_COL  = COLUMN_COUNT - 1;

   // frame store and per-byte valid bits; an unwritten byte reads as bg_ff
   logic [7:0]       mem [DEPTH];
   logic [DEPTH-1:0] valid_ff, valid_in;
   logic [7:0]       bg_ff, bg_in;

   // scan state
   logic [7:0]     timer_ff, timer_in;
   logic [BCW-1:0] bc_ff, bc_in;
   logic [2:0]     nc_ff, nc_in;
   logic [2:0]     dc_ff, dc_in;
   logic           blank_ff, blank_in;

   // captured request
   lmsd_pkg::kind_type kind_ff;
   logic [7:0]         bright_ff;
   logic               done_ff;
   logic [AW-1:0]      addr_ff;
   logic [2:0]         bit_ff;
   logic               pix_ok_ff;
   logic [7:0]         rd_data_ff;
   logic               rd_valid_ff;

   // result register
   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_start_ff;
   logic       rsp_latch_ff;
   logic [2:0] rsp_col_ff;
   logic       rsp_blank_ff;

   logic [7:0]    timer_inc;
   logic          bc_last;
   logic [2:0]    nc_wrap;
   logic [AW-1:0] tick_addr;
   logic [BCW-1:0] bc_inc;
   logic [2:0]    pix_row;
   logic [7:0]    pix_idx;
   logic [2:0]    pix_bit;
   logic          pix_ok;
   logic [AW-1:0] rd_addr;
   logic          adv, lat, is_tick, is_pix;
   logic [7:0]    cur_byte;
   logic [7:0]    bit_mask;
   logic [7:0]    wr_byte;
   logic          mem_we;

   function automatic logic [AW-1:0] fetch_idx(input logic [BCW-1:0] bc,
                                               input logic [2:0] col);
      logic [7:0] base;
      logic [7:0] sum;
      base = lmsd_pkg::BYTES_PER_PANEL * 8'(bc >> 1);
      sum  = base + {4'b0000, col, 1'b0} + 8'(bc[0]);
      return AW'(sum);
   endfunction

   assign timer_inc = timer_ff + 8'd1;
   assign bc_last   = (bc_ff == BCW'(LAST_BYTE));
   assign bc_inc    = bc_ff + BCW'(1);
   assign nc_wrap   = (nc_ff == 3'(LAST_COL)) ? 3'd0 : nc_ff + 3'd1;
   assign tick_addr = bc_last ? fetch_idx('0, nc_wrap) : fetch_idx(bc_inc, nc_ff);

   // map pixel to byte and bit of the panel layout
   always_comb begin
      pix_row = req_pixel_y[2:0];
      pix_ok  = (req_pixel_x < lmsd_pkg::PIXEL_COLS) && (8'(req_pixel_y) < 8'(ROWS));
      if (req_pixel_x[3] == 1'b0) begin
         pix_idx = {5'b00000, pix_row ^ 3'b001};
         pix_bit = req_pixel_x[2:0];
      end else begin
         pix_idx = 8'd8 + {6'b000000, pix_row[2:1] ^ 2'b01};
         pix_bit = {pix_row[0], req_pixel_x[1:0]};
      end
      if (req_pixel_y[3]) pix_idx = pix_idx + lmsd_pkg::BYTES_PER_PANEL;
   end

   always_comb begin
      if (req_kind == lmsd_pkg::KIND_TICK) begin
         rd_addr = tick_addr;
      end else if (pix_ok) begin
         rd_addr = AW'(pix_idx);
      end else begin
         rd_addr = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff     <= req_kind;
         bright_ff   <= req_brightness;
         done_ff     <= req_shift_done;
         addr_ff     <= rd_addr;
         bit_ff      <= pix_bit;
         pix_ok_ff   <= pix_ok;
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
      if (mem_we) mem[addr_ff] <= wr_byte;
   end

   assign is_tick  = (kind_ff == lmsd_pkg::KIND_TICK);
   assign is_pix   = ((kind_ff == lmsd_pkg::KIND_SET) || (kind_ff == lmsd_pkg::KIND_CLEAR))
                     && pix_ok_ff;
   assign adv      = is_tick && done_ff && !bc_last;
   assign lat      = is_tick && done_ff && bc_last && (timer_inc > row_period);
   assign cur_byte = rd_valid_ff ? rd_data_ff : bg_ff;
   assign bit_mask = 8'd1 << bit_ff;
   assign wr_byte  = (kind_ff == lmsd_pkg::KIND_SET) ? (cur_byte | bit_mask)
                                                    : (cur_byte & ~bit_mask);
   assign mem_we   = cmd.commit && is_pix;

   always_comb begin
      valid_in = valid_ff;
      bg_in    = bg_ff;
      timer_in = timer_ff;
      bc_in    = bc_ff;
      nc_in    = nc_ff;
      dc_in    = dc_ff;
      blank_in = blank_ff;
      if (is_pix) valid_in[addr_ff] = 1'b1;
      if (kind_ff == lmsd_pkg::KIND_CLEAR_ALL) begin
         valid_in = '0;
         bg_in    = lmsd_pkg::BYTE_CLEAR;
      end
      if (kind_ff == lmsd_pkg::KIND_FILL_ALL) begin
         valid_in = '0;
         bg_in    = lmsd_pkg::BYTE_FILL;
      end
      if (is_tick) begin
         timer_in = timer_inc;
         if (adv) bc_in = bc_inc;
         if (lat) begin
            timer_in = 8'd0;
            bc_in    = '0;
            dc_in    = nc_ff;
            nc_in    = nc_wrap;
            blank_in = 1'b0;
         end
         if (timer_in >= bright_ff) blank_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         bg_ff    <= lmsd_pkg::BYTE_CLEAR;
         timer_ff <= 8'd0;
         bc_ff    <= '0;
         nc_ff    <= 3'd0;
         dc_ff    <= 3'd0;
         blank_ff <= 1'b0;
      end else if (cmd.commit) begin
         valid_ff <= valid_in;
         bg_ff    <= bg_in;
         timer_ff <= timer_in;
         bc_ff    <= bc_in;
         nc_ff    <= nc_in;
         dc_ff    <= dc_in;
         blank_ff <= blank_in;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_byte_ff  <= (adv || lat) ? cur_byte : 8'd0;
         rsp_start_ff <= adv || lat;
         rsp_latch_ff <= lat;
         rsp_col_ff   <= dc_in;
         rsp_blank_ff <= blank_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_shift_byte    = rsp_byte_ff;
   assign rsp_shift_start   = rsp_start_ff;
   assign rsp_latch_pulse   = rsp_latch_ff;
   assign rsp_column_select = rsp_col_ff;
   assign rsp_blank         = rsp_blank_ff;

endmodule

// File: design/led_matrix_scan_driver.sv
// A request is accepted only in idle and the frame store is read as it is captured;
// the result register is loaded by the read-modify-write commit on the store's
// single port, so no new request is taken until the last one has committed; clear
// and fill take one commit through a background byte. A full result register stalls the commit.
// Reset (synchronous, active high) clears scan state and the result valid flag,
// makes every frame byte read as zero and sets row_period to 128.
module led_matrix_scan_driver #(
   parameter int PANEL_COUNT  = 2,
   parameter int COLUMN_COUNT = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [7:0]  req_brightness,
   input  logic        req_shift_done,
   input  logic [3:0]  req_pixel_x,
   input  logic [3:0]  req_pixel_y,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_shift_byte,
   output logic        rsp_shift_start,
   output logic        rsp_latch_pulse,
   output logic [2:0]  rsp_column_select,
   output logic        rsp_blank,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   lmsd_pkg::lmsd_cmd_type    cmd;
   lmsd_pkg::lmsd_status_type status;

   logic [7:0] row_period_ff;
   logic       csr_hit;

   assign csr_hit    = (csr_paddr[2] == 1'b0);
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? {24'd0, row_period_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_period_ff <= lmsd_pkg::ROW_PERIOD_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         row_period_ff <= csr_pwdata[7:0];
      end
   end

   lmsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lmsd_datapath #(
      .PANEL_COUNT  (PANEL_COUNT),
      .COLUMN_COUNT (COLUMN_COUNT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .row_period        (row_period_ff),
      .req_kind          (req_kind),
      .req_brightness    (req_brightness),
      .req_shift_done    (req_shift_done),
      .req_pixel_x       (req_pixel_x),
      .req_pixel_y       (req_pixel_y),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_shift_byte    (rsp_shift_byte),
      .rsp_shift_start   (rsp_shift_start),
      .rsp_latch_pulse   (rsp_latch_pulse),
      .rsp_column_select (rsp_column_select),
      .rsp_blank         (rsp_blank)
   );

endmodule
